// ===== sv/assert_macros.svh =====
// Assertion macros shared by the K-line frame checker RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define KWPFC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("kwpfc assertion failed");
`define KWPFC_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("kwpfc forbidden condition seen");
`else
`define KWPFC_ASSERT(name, clk, rst_n, prop)
`define KWPFC_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ===== sv/kwpfc_pkg.sv =====
// Package of the K-line response frame checker: sizes, status codes and types.
// No dependencies; used by the interfaces, the top level and the bench.
package kwpfc_pkg;

  localparam int unsigned BUFFER_BYTES = 64;
  localparam int unsigned STORE_DEPTH  = 63;
  localparam int unsigned STORE_AW     = $clog2(STORE_DEPTH);
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned LEFT_W       = 7;

  localparam logic [LEFT_W-1:0] CAPACITY   = LEFT_W'(BUFFER_BYTES);
  localparam logic [LEFT_W-1:0] TAIL_BYTES = 7'd3;
  localparam logic [LEFT_W-1:0] FRAME_OVH  = 7'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TIMEOUT   = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_BAD_SUM   = 2'd3;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    S_RX,
    S_PEND,
    S_RD,
    S_OUT
  } kwpfc_state_e;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       data_byte;
    logic             data_valid;
    logic [LEN_W-1:0] data_count;
    logic             last;
  } kwpfc_res_t;

endpackage

// ===== sv/kwpfc_if.sv =====
// Valid/ready channel interfaces for received words and result words.
// Depends on kwpfc_pkg.
interface kwpfc_in_if;
  import kwpfc_pkg::*;

  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface kwpfc_out_if;
  import kwpfc_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [7:0]       data_byte;
  logic             data_valid;
  logic [LEN_W-1:0] data_count;
  logic             last;

  modport source (output valid, output status, output data_byte, output data_valid,
                  output data_count, output last, input ready);
  modport sink   (input valid, input status, input data_byte, input data_valid,
                  input data_count, input last, output ready);
endinterface

// ===== sv/kwpfc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kwpfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 63,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/kwp_response_frame_checker_top.sv =====
// Top level of the K-line response frame checker.
// Depends on kwpfc_pkg, kwpfc_if, kwpfc_ram and assert_macros.svh.
//
// Received bytes are taken one word per cycle while a frame is being
// collected; payload bytes go into a 63-entry payload memory. A timeout, an
// oversized frame, a bad checksum or an empty good frame yields one status
// word. After the checksum of a good frame with L payload bytes the block
// reads the memory back and sends L words, each through a read state and an
// output state, so no input is taken until the last word is in the result
// register; this is set by the single read port of the payload memory and
// its registered read data. The result register lets the next input be
// taken while a result still waits.
`include "assert_macros.svh"

module kwp_response_frame_checker_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  kwpfc_in_if.sink     rx_i,
  kwpfc_out_if.source  res_o
);
  import kwpfc_pkg::*;

  kwpfc_state_e        state_q, state_d;
  logic                recv_q, recv_d;
  logic [LEFT_W-1:0]   left_q, left_d;
  logic [7:0]          sum_q, sum_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [LEN_W-1:0]    widx_q, widx_d;
  logic [LEN_W-1:0]    ridx_q, ridx_d;
  logic [1:0]          pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  kwpfc_res_t          out_q, out_d;

  logic                acc;
  logic                out_free;
  logic                single;
  logic [1:0]          single_st;
  logic [LEN_W-1:0]    rx_len;
  logic                ram_we;
  logic                ram_re;
  logic [7:0]          ram_rdata;
  logic                drain_last;

  assign acc        = rx_i.valid && rx_i.ready;
  assign out_free   = !out_valid_q || res_o.ready;
  assign rx_len     = rx_i.rx_byte[LEN_W-1:0];
  assign drain_last = (ridx_q + LEN_W'(1)) == len_q;

  kwpfc_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q[STORE_AW-1:0]),
    .wdata_i (rx_i.rx_byte),
    .re_i    (ram_re),
    .raddr_i (ridx_q[STORE_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    recv_d      = recv_q;
    left_d      = left_q;
    sum_d       = sum_q;
    len_d       = len_q;
    widx_d      = widx_q;
    ridx_d      = ridx_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    single      = 1'b0;
    single_st   = ST_OK;

    unique case (state_q)
      S_RX: begin
        if (acc) begin
          if (rx_i.op == OP_TIMEOUT) begin
            single    = 1'b1;
            single_st = ST_TIMEOUT;
          end else if (!recv_q) begin
            if (({1'b0, rx_len} + FRAME_OVH) > CAPACITY) begin
              single    = 1'b1;
              single_st = ST_TOO_LARGE;
            end else begin
              recv_d = 1'b1;
              len_d  = rx_len;
              left_d = {1'b0, rx_len} + TAIL_BYTES;
              sum_d  = rx_i.rx_byte;
              widx_d = '0;
            end
          end else if (left_q > LEFT_W'(1)) begin
            if (left_q <= ({1'b0, len_q} + LEFT_W'(1))) begin
              ram_we = (32'(widx_q) < STORE_DEPTH);
              widx_d = widx_q + LEN_W'(1);
            end
            sum_d  = sum_q + rx_i.rx_byte;
            left_d = left_q - LEFT_W'(1);
          end else begin
            recv_d = 1'b0;
            left_d = '0;
            if (sum_q != rx_i.rx_byte) begin
              single    = 1'b1;
              single_st = ST_BAD_SUM;
            end else if (len_q == '0) begin
              single    = 1'b1;
              single_st = ST_OK;
            end else begin
              ridx_d  = '0;
              state_d = S_RD;
            end
          end
          if (single) begin
            recv_d = 1'b0;
            left_d = '0;
            if (out_free) begin
              out_d       = '{status: single_st, data_byte: 8'd0, data_valid: 1'b0,
                              data_count: '0, last: 1'b1};
              out_valid_d = 1'b1;
            end else begin
              pend_d  = single_st;
              state_d = S_PEND;
            end
          end
        end
      end
      S_PEND: begin
        if (out_free) begin
          out_d       = '{status: pend_q, data_byte: 8'd0, data_valid: 1'b0,
                          data_count: '0, last: 1'b1};
          out_valid_d = 1'b1;
          state_d     = S_RX;
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_d       = '{status: ST_OK, data_byte: ram_rdata, data_valid: 1'b1,
                          data_count: len_q, last: drain_last};
          out_valid_d = 1'b1;
          if (drain_last) begin
            state_d = S_RX;
          end else begin
            ridx_d  = ridx_q + LEN_W'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_RX;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RX;
      recv_q      <= 1'b0;
      left_q      <= '0;
      sum_q       <= '0;
      len_q       <= '0;
      widx_q      <= '0;
      ridx_q      <= '0;
      pend_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      recv_q      <= recv_d;
      left_q      <= left_d;
      sum_q       <= sum_d;
      len_q       <= len_d;
      widx_q      <= widx_d;
      ridx_q      <= ridx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rx_i.ready       = (state_q == S_RX);
  assign res_o.valid      = out_valid_q;
  assign res_o.status     = out_q.status;
  assign res_o.data_byte  = out_q.data_byte;
  assign res_o.data_valid = out_q.data_valid;
  assign res_o.data_count = out_q.data_count;
  assign res_o.last       = out_q.last;

  `KWPFC_NEVER(a_no_write_in_drain, clk_i, rst_ni, ram_we && (state_q == S_RD || state_q == S_OUT))
  `KWPFC_ASSERT(a_drain_in_range, clk_i, rst_ni, (state_q == S_RD) |-> (ridx_q < len_q))
  `KWPFC_ASSERT(a_recv_has_bytes, clk_i, rst_ni, recv_q |-> (left_q != '0))
  `KWPFC_ASSERT(a_data_has_count, clk_i, rst_ni, (out_valid_q && out_q.data_valid) |-> (out_q.data_count != '0))

endmodule

// ===== bench/tb_kwp_response_frame_checker_top.sv =====
// Self-checking bench for the K-line response frame checker top level.
// Depends on kwpfc_pkg and kwpfc_if; builds its expected result words from an internal
// frame tracker and compares them in order with the words the block delivers.
module tb_kwp_response_frame_checker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kwpfc_pkg::*;

  typedef enum logic [1:0] {
    FRAME_IDLE = 2'd0,
    FRAME_BODY = 2'd1
  } frame_phase_e;

  localparam int WATCHDOG_CYCLES = 1000;
  localparam int RANDOM_WORDS    = 148;
  localparam int DRAIN_CYCLES    = 40;

  logic clk_i;
  logic rst_ni;

  kwpfc_in_if  rx_if ();
  kwpfc_out_if res_if ();

  kwp_response_frame_checker_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  frame_phase_e    frame_phase;
  logic [6:0]      bytes_due;
  logic [7:0]      frame_sum;
  logic [5:0]      frame_len;
  logic [5:0]      store_ptr;
  logic [7:0]      payload_mem [STORE_DEPTH];
  kwpfc_res_t      result_words_due [$];

  int mismatches;
  int words_sent;
  int burst_left;
  int idle_cycles;
  bit gaps_on;
  int ready_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int pat_cnt;
    pat_cnt = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      pat_cnt++;
      case (ready_mode)
        0: begin
          res_if.ready <= 1'b1;
        end
        1: begin
          res_if.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          res_if.ready <= !(((pat_cnt % 13) >= 10) || ((pat_cnt % 5) == 0));
        end
      endcase
    end
  end

  task automatic close_frame(input logic [1:0] status);
    kwpfc_res_t w;
    w.status     = status;
    w.data_byte  = 8'd0;
    w.data_valid = 1'b0;
    w.data_count = '0;
    w.last       = 1'b1;
    frame_phase  = FRAME_IDLE;
    bytes_due    = 7'd0;
    result_words_due.push_back(w);
  endtask

  task automatic track_rx_word(input logic op, input logic [7:0] b);
    kwpfc_res_t w;
    if (op == OP_TIMEOUT) begin
      close_frame(ST_TIMEOUT);
    end else if (frame_phase != FRAME_BODY) begin
      if (int'(b[5:0]) + int'(FRAME_OVH) > int'(CAPACITY)) begin
        close_frame(ST_TOO_LARGE);
      end else begin
        frame_phase = FRAME_BODY;
        frame_len   = b[5:0];
        bytes_due   = {1'b0, b[5:0]} + TAIL_BYTES;
        frame_sum   = b;
        store_ptr   = 6'd0;
      end
    end else if (bytes_due > 7'd1) begin
      if (bytes_due <= {1'b0, frame_len} + 7'd1) begin
        if (int'(store_ptr) < STORE_DEPTH) payload_mem[store_ptr] = b;
        store_ptr = store_ptr + 6'd1;
      end
      frame_sum = frame_sum + b;
      bytes_due = bytes_due - 7'd1;
    end else if (frame_sum != b) begin
      close_frame(ST_BAD_SUM);
    end else if (frame_len == 6'd0) begin
      close_frame(ST_OK);
    end else begin
      frame_phase = FRAME_IDLE;
      bytes_due   = 7'd0;
      for (int k = 0; k < int'(frame_len); k++) begin
        w.status     = ST_OK;
        w.data_byte  = payload_mem[k];
        w.data_valid = 1'b1;
        w.data_count = frame_len;
        w.last       = (k == int'(frame_len) - 1);
        result_words_due.push_back(w);
      end
    end
  endtask

  task automatic send_word(input logic op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_if.valid   <= 1'b1;
    rx_if.op      <= op;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    words_sent++;
    track_rx_word(op, b);
  endtask

  // A cut of n sends a timeout in place of the n-th byte after the format byte.
  task automatic send_frame(input logic [1:0] fmt_hi, input int len, input logic [7:0] fill,
                            input bit use_fill, input logic [7:0] sum_delta, input int cut);
    logic [7:0] fmt;
    logic [7:0] sum;
    logic [7:0] v;
    fmt = {fmt_hi, 6'(len)};
    sum = fmt;
    send_word(OP_BYTE, fmt);
    for (int n = 1; n <= len + 3; n++) begin
      if (n == cut) begin
        send_word(OP_TIMEOUT, 8'($urandom));
        return;
      end
      if (n == len + 3) begin
        send_word(OP_BYTE, sum + sum_delta);
      end else begin
        v = use_fill ? fill : 8'($urandom);
        sum = sum + v;
        send_word(OP_BYTE, v);
      end
    end
  endtask

  task automatic test_empty_frame;
    ready_mode = 0;
    gaps_on    = 1'b0;
    send_frame(2'b00, 0, 8'h00, 1'b1, 8'h00, -1);
  endtask

  task automatic test_all_ones_frame;
    ready_mode = 1;
    gaps_on    = 1'b1;
    send_frame(2'b11, 2, 8'hFF, 1'b1, 8'h00, -1);
  endtask

  task automatic test_checksum_error;
    ready_mode = 2;
    send_frame(2'b01, 1, 8'h5A, 1'b1, 8'h01, -1);
  endtask

  task automatic test_oversized_frames;
    gaps_on = 1'b0;
    send_word(OP_BYTE, 8'h3D);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h7E);
  endtask

  task automatic test_timeouts;
    gaps_on = 1'b1;
    send_word(OP_TIMEOUT, 8'hFF);
    send_frame(2'b10, 3, 8'h00, 1'b0, 8'h00, 3);
  endtask

  task automatic test_random_traffic;
    int first_word;
    int frames;
    int pick;
    int len;
    int cut;
    logic [7:0] delta;
    first_word = words_sent;
    frames     = 0;
    while (words_sent - first_word < RANDOM_WORDS) begin
      ready_mode = $urandom_range(0, 2);
      gaps_on    = ($urandom_range(0, 3) != 0);
      pick       = $urandom_range(0, 99);
      if (pick < 5) begin
        send_word(OP_TIMEOUT, 8'($urandom));
      end else if (pick < 10) begin
        send_word(OP_BYTE, {2'($urandom_range(0, 3)), 6'($urandom_range(61, 63))});
      end else if (pick < 14) begin
        send_word(OP_BYTE, 8'($urandom));
        send_word(OP_TIMEOUT, 8'($urandom));
      end else begin
        if (frames == 2) len = 60;
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 60);
        else len = $urandom_range(0, 6);
        cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len + 3) : -1;
        delta = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        send_frame(2'($urandom_range(0, 3)), len, 8'h00, 1'b0, delta, cut);
        frames++;
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    kwpfc_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (result_words_due.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual status %0d byte %0d",
                 $time, res_if.status, res_if.data_byte);
        mismatches++;
      end else begin
        want = result_words_due.pop_front();
        check_field("status", int'(want.status), int'(res_if.status));
        check_field("data_byte", int'(want.data_byte), int'(res_if.data_byte));
        check_field("data_valid", int'(want.data_valid), int'(res_if.data_valid));
        check_field("data_count", int'(want.data_count), int'(res_if.data_count));
        check_field("last", int'(want.last), int'(res_if.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL kwp_response_frame_checker_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.op      <= OP_BYTE;
    rx_if.rx_byte <= 8'h00;
    mismatches  = 0;
    words_sent  = 0;
    burst_left  = 0;
    gaps_on     = 1'b0;
    ready_mode  = 0;
    frame_phase = FRAME_IDLE;
    bytes_due   = 7'd0;
    frame_sum   = 8'd0;
    frame_len   = 6'd0;
    store_ptr   = 6'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_frame();
    test_all_ones_frame();
    test_checksum_error();
    test_oversized_frames();
    test_timeouts();
    test_random_traffic();

    rx_if.valid <= 1'b0;
    ready_mode = 1;
    while (result_words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS kwp_response_frame_checker_top");
    end else begin
      $display("FAIL kwp_response_frame_checker_top");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/kwpfc_pkg.sv
sv/kwpfc_if.sv
sv/kwpfc_ram.sv
sv/kwp_response_frame_checker_top.sv
bench/tb_kwp_response_frame_checker_top.sv
